@@ sv/e2h_pkg.sv @@
// ----------------------------------------------------------------------------
// e2h_pkg: shared constants and helpers for the equatorial to horizontal unit
// Fixed-point formats, turn fractions and the elaboration-time functions that
// build the CORDIC arctangent entries and the CORDIC gain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package e2h_pkg;

  // Default sizes of the unit.
  localparam int ANGLE_BITS_DEF    = 32;
  localparam int CORDIC_STAGES_DEF = 32;

  // Internal angles are Q64 fractions of a turn; vector values are signed Q60.
  localparam int                 FRAC        = 60;
  localparam logic signed [63:0] FX_ONE      = 64'sh1000_0000_0000_0000;
  localparam logic        [63:0] TURN_EIGHTH = 64'h2000_0000_0000_0000;
  localparam logic        [63:0] TURN_QUART  = 64'h4000_0000_0000_0000;
  localparam logic        [63:0] TURN_HALF   = 64'h8000_0000_0000_0000;
  localparam logic        [63:0] INV_TWO_PI  = 64'h28BE_60DB_9391_054A;
  localparam logic signed [63:0] GAIN_SEED   = FX_ONE / 10 * 6;

  // Quadrant of an angle after folding to the nearest quarter turn.
  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_e;

  // Signed Q60 product, magnitude truncated toward zero (constants only).
  function automatic logic signed [63:0] fmul_c(input logic signed [63:0] a,
                                                input logic signed [63:0] b);
    logic [63:0]  ua;
    logic [63:0]  ub;
    logic [63:0]  m;
    logic [127:0] pr;
    logic         neg;
    neg = a[63] ^ b[63];
    ua  = a[63] ? 64'(-a) : 64'(a);
    ub  = b[63] ? 64'(-b) : 64'(b);
    pr  = {64'd0, ua} * {64'd0, ub};
    m   = pr[123:60];
    return neg ? $signed(-m) : $signed(m);
  endfunction

  // Arctangent of 2^-i as a Q64 fraction of a turn.
  function automatic logic signed [63:0] atan_entry(input int i);
    logic [63:0]  acc;
    logic [63:0]  term;
    logic [127:0] pr;
    int           e;
    acc = '0;
    if (i == 0) begin
      return $signed(TURN_EIGHTH);
    end
    for (int k = 0; k < 32; k++) begin
      e = 62 - i * (2 * k + 1);
      if (e >= 0) begin
        term = (64'd1 << e) / 64'(2 * k + 1);
        if ((k & 1) != 0) begin
          acc = acc - term;
        end else begin
          acc = acc + term;
        end
      end
    end
    pr = {64'd0, acc} * {64'd0, INV_TWO_PI};
    return $signed(pr[125:62]);
  endfunction

  // Magnitude that a vectoring pass of (1, 0) returns.
  function automatic logic signed [63:0] gain_k_calc(input int n);
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] dx;
    logic signed [63:0] dy;
    x = FX_ONE;
    y = '0;
    for (int i = 0; i < n; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (!y[63]) begin
        x = x + dx;
        y = y - dy;
      end else begin
        x = x - dx;
        y = y + dy;
      end
    end
    return x;
  endfunction

  // Reciprocal of the gain by Newton steps.
  function automatic logic signed [63:0] gain_inv_calc(input int n);
    logic signed [63:0] k;
    logic signed [63:0] g;
    k = gain_k_calc(n);
    g = GAIN_SEED;
    for (int j = 0; j < 8; j++) begin
      g = fmul_c(g, (FX_ONE <<< 1) - fmul_c(k, g));
    end
    return g;
  endfunction

endpackage

`default_nettype wire

@@ sv/e2h_dly.sv @@
// ----------------------------------------------------------------------------
// e2h_dly: side-data delay line
// Carries side data alongside a pipelined unit; it moves one place on enable.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module e2h_dly #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  wire logic         clk_i,
  input  wire logic         en_i,
  input  wire logic [W-1:0] d_i,
  output logic      [W-1:0] q_o
);

  logic [W-1:0] tap_q [DEPTH];

  // Shift the line on every enabled cycle.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tap_q[0] <= d_i;
      for (int j = 1; j < DEPTH; j++) begin
        tap_q[j] <= tap_q[j-1];
      end
    end
  end

  assign q_o = tap_q[DEPTH-1];

endmodule

`default_nettype wire

@@ sv/e2h_fmul.sv @@
// ----------------------------------------------------------------------------
// e2h_fmul: pipelined signed Q60 multiplier
// Sign-magnitude product built from four 32x32 partial products over three
// stages; the magnitude is truncated toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module e2h_fmul (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [63:0] a_i,
  input  wire logic signed [63:0] b_i,
  output logic signed      [63:0] p_o
);

  logic         neg1_q;
  logic         neg2_q;
  logic [63:0]  ua_q;
  logic [63:0]  ub_q;
  logic [63:0]  ll_q;
  logic [63:0]  lh_q;
  logic [63:0]  hl_q;
  logic [63:0]  hh_q;
  logic [127:0] sum;
  logic [63:0]  mag;

  // Stage 1: magnitudes and product sign.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg1_q <= a_i[63] ^ b_i[63];
      ua_q   <= a_i[63] ? 64'(-a_i) : 64'(a_i);
      ub_q   <= b_i[63] ? 64'(-b_i) : 64'(b_i);
    end
  end

  // Stage 2: four partial products.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg2_q <= neg1_q;
      ll_q   <= ua_q[31:0]  * ub_q[31:0];
      lh_q   <= ua_q[31:0]  * ub_q[63:32];
      hl_q   <= ua_q[63:32] * ub_q[31:0];
      hh_q   <= ua_q[63:32] * ub_q[63:32];
    end
  end

  // Stage 3: sum, drop the fraction bits and restore the sign.
  assign sum = {hh_q, ll_q} + {32'd0, lh_q, 32'd0} + {32'd0, hl_q, 32'd0};
  assign mag = sum[123:60];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o <= neg2_q ? $signed(-mag) : $signed(mag);
    end
  end

endmodule

`default_nettype wire

@@ sv/e2h_rot.sv @@
// ----------------------------------------------------------------------------
// e2h_rot: pipelined rotation CORDIC for sine and cosine
// Folds a Q64 angle to the nearest quarter turn, rotates the residual one
// stage per register, then maps the quadrant back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module e2h_rot
  import e2h_pkg::*;
#(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic        [63:0] th_i,
  output logic signed      [63:0] cos_o,
  output logic signed      [63:0] sin_o
);

  localparam logic signed [63:0] GAIN_INV = gain_inv_calc(STAGES);

  logic        [63:0] shifted;
  logic signed [63:0] res;
  logic signed [63:0] x0_q;
  logic signed [63:0] y0_q;
  logic signed [63:0] r0_q;
  quad_e              q0_q;
  logic               z0_q;

  logic signed [63:0] x_q [STAGES];
  logic signed [63:0] y_q [STAGES];
  logic signed [63:0] r_q [STAGES];
  quad_e              q_q [STAGES];
  logic               z_q [STAGES];

  logic signed [63:0] xf;
  logic signed [63:0] yf;

  // Fold to the nearest quarter turn.
  assign shifted = th_i + TURN_EIGHTH;
  assign res     = $signed({2'b00, shifted[61:0]}) - $signed(TURN_EIGHTH);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x0_q <= GAIN_INV;
      y0_q <= '0;
      r0_q <= res;
      q0_q <= quad_e'(shifted[63:62]);
      z0_q <= (res == '0);
    end
  end

  // One micro-rotation per stage.
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [63:0] ATAN = atan_entry(i);
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    logic signed [63:0] rs;
    quad_e              qs;
    logic               zs;

    if (i == 0) begin : g_first
      assign xs = x0_q;
      assign ys = y0_q;
      assign rs = r0_q;
      assign qs = q0_q;
      assign zs = z0_q;
    end else begin : g_next
      assign xs = x_q[i-1];
      assign ys = y_q[i-1];
      assign rs = r_q[i-1];
      assign qs = q_q[i-1];
      assign zs = z_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!rs[63]) begin
          x_q[i] <= xs - (ys >>> i);
          y_q[i] <= ys + (xs >>> i);
          r_q[i] <= rs - ATAN;
        end else begin
          x_q[i] <= xs + (ys >>> i);
          y_q[i] <= ys - (xs >>> i);
          r_q[i] <= rs + ATAN;
        end
        q_q[i] <= qs;
        z_q[i] <= zs;
      end
    end
  end

  // A zero residual uses the unit vector exactly.
  assign xf = z_q[STAGES-1] ? FX_ONE : x_q[STAGES-1];
  assign yf = z_q[STAGES-1] ? '0 : y_q[STAGES-1];

  // Map the quadrant back.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unique case (q_q[STAGES-1])
        QUAD_0: begin
          cos_o <= xf;
          sin_o <= yf;
        end
        QUAD_1: begin
          cos_o <= -yf;
          sin_o <= xf;
        end
        QUAD_2: begin
          cos_o <= -xf;
          sin_o <= -yf;
        end
        QUAD_3: begin
          cos_o <= yf;
          sin_o <= -xf;
        end
        default: begin
          cos_o <= xf;
          sin_o <= yf;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/e2h_vec.sv @@
// ----------------------------------------------------------------------------
// e2h_vec: pipelined vectoring CORDIC
// Drives y toward zero one stage per register and accumulates the angle as a
// Q64 fraction of a turn; x ends as the scaled magnitude.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module e2h_vec
  import e2h_pkg::*;
#(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [63:0] x_i,
  input  wire logic signed [63:0] y_i,
  output logic signed      [63:0] ang_o,
  output logic signed      [63:0] mag_o
);

  logic signed [63:0] x_q [STAGES];
  logic signed [63:0] y_q [STAGES];
  logic signed [63:0] z_q [STAGES];

  // One micro-rotation per stage.
  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [63:0] ATAN = atan_entry(i);
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    logic signed [63:0] zs;

    if (i == 0) begin : g_first
      assign xs = x_i;
      assign ys = y_i;
      assign zs = '0;
    end else begin : g_next
      assign xs = x_q[i-1];
      assign ys = y_q[i-1];
      assign zs = z_q[i-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!ys[63]) begin
          x_q[i] <= xs + (ys >>> i);
          y_q[i] <= ys - (xs >>> i);
          z_q[i] <= zs + ATAN;
        end else begin
          x_q[i] <= xs - (ys >>> i);
          y_q[i] <= ys + (xs >>> i);
          z_q[i] <= zs - ATAN;
        end
      end
    end
  end

  assign ang_o = z_q[STAGES-1];
  assign mag_o = x_q[STAGES-1];

endmodule

`default_nettype wire

@@ sv/equatorial_to_horizontal_unit.sv @@
// ----------------------------------------------------------------------------
// equatorial_to_horizontal_unit: equatorial to horizontal coordinate converter
// Turns declination and hour angle into elevation and azimuth for the site
// latitude held in a register, through pipelined CORDIC units and multipliers.
// ----------------------------------------------------------------------------
// Three CORDIC pipelines in series with three multiplier rounds.
// Throughput: one request per cycle while in_stall_o is low; a two-entry
// output stage absorbs stalls.
// Reset: asynchronous, active low; clears all valid bits and sets the latitude
// register to zero.
`timescale 1ns / 1ps
`default_nettype none

module equatorial_to_horizontal_unit
  import e2h_pkg::*;
#(
  parameter int ANGLE_BITS    = ANGLE_BITS_DEF,
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // Latitude register write
  input  wire logic                         cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire logic signed [ANGLE_BITS-1:0] cfg_data_i,
  // Request channel
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [ANGLE_BITS-1:0] declination_i,
  input  wire logic        [ANGLE_BITS-1:0] hour_angle_i,
  // Result channel
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic signed      [ANGLE_BITS-1:0] elevation_o,
  output logic             [ANGLE_BITS-1:0] azimuth_o,
  output logic                              degenerate_o
);

  localparam int                 SHIFT    = 64 - ANGLE_BITS;
  localparam int                 LAT      = 3 * CORDIC_STAGES + 13;
  localparam int                 RES_W    = 2 * ANGLE_BITS + 1;
  localparam logic        [63:0] HALF_LSB = 64'd1 << (SHIFT - 1);
  localparam logic signed [63:0] GAIN_K   = gain_k_calc(CORDIC_STAGES);

  logic signed [ANGLE_BITS-1:0] lat_q;
  logic                         en;
  logic [LAT-1:0]               vld_q;
  logic                         skid_v_q;

  // Latitude register.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      lat_q <= cfg_data_i;
    end
  end

  // The pipeline moves whenever the skid entry is free.
  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[LAT-2:0], in_valid_i};
    end
  end

  // Sine and cosine of the three angles.
  logic signed [63:0] cd, sd, ch, sh, cl, sl;

  e2h_rot #(.STAGES(CORDIC_STAGES)) u_rot_dec (
    .clk_i(clk_i), .en_i(en), .th_i({declination_i, {SHIFT{1'b0}}}),
    .cos_o(cd), .sin_o(sd)
  );
  e2h_rot #(.STAGES(CORDIC_STAGES)) u_rot_ha (
    .clk_i(clk_i), .en_i(en), .th_i({hour_angle_i, {SHIFT{1'b0}}}),
    .cos_o(ch), .sin_o(sh)
  );
  e2h_rot #(.STAGES(CORDIC_STAGES)) u_rot_lat (
    .clk_i(clk_i), .en_i(en), .th_i({lat_q, {SHIFT{1'b0}}}),
    .cos_o(cl), .sin_o(sl)
  );

  // First multiplier round.
  logic signed [63:0] cdch, m1, yv, m3;
  logic signed [63:0] sl_b, cl_b;
  logic               clz_b;

  e2h_fmul u_mul_cdch (.clk_i(clk_i), .en_i(en), .a_i(cd), .b_i(ch), .p_o(cdch));
  e2h_fmul u_mul_m1   (.clk_i(clk_i), .en_i(en), .a_i(cl), .b_i(sd), .p_o(m1));
  e2h_fmul u_mul_y    (.clk_i(clk_i), .en_i(en), .a_i(sh), .b_i(cd), .p_o(yv));
  e2h_fmul u_mul_m3   (.clk_i(clk_i), .en_i(en), .a_i(sl), .b_i(sd), .p_o(m3));

  e2h_dly #(.W(129), .DEPTH(3)) u_dly_lat (
    .clk_i(clk_i), .en_i(en), .d_i({sl, cl, cl == '0}), .q_o({sl_b, cl_b, clz_b})
  );

  // Second multiplier round.
  logic signed [63:0] m2, m4, m1_c, m3_c, y_c;
  logic               clz_c;

  e2h_fmul u_mul_m2 (.clk_i(clk_i), .en_i(en), .a_i(sl_b), .b_i(cdch), .p_o(m2));
  e2h_fmul u_mul_m4 (.clk_i(clk_i), .en_i(en), .a_i(cl_b), .b_i(cdch), .p_o(m4));

  e2h_dly #(.W(193), .DEPTH(3)) u_dly_prod (
    .clk_i(clk_i), .en_i(en), .d_i({m1, m3, yv, clz_b}), .q_o({m1_c, m3_c, y_c, clz_c})
  );

  // Direction vector, degenerate test and half-plane fold.
  logic signed [63:0] x_raw, z_raw;
  logic signed [63:0] cx_q, cy_q, cz_q;
  logic               cdeg_q, cbase_q;

  assign x_raw = m1_c - m2;
  assign z_raw = m3_c + m4;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cx_q    <= x_raw[63] ? -x_raw : x_raw;
      cy_q    <= x_raw[63] ? -y_c : y_c;
      cz_q    <= z_raw;
      cdeg_q  <= clz_c || (x_raw == '0 && y_c == '0);
      cbase_q <= x_raw[63];
    end
  end

  // Azimuth vectoring.
  logic signed [63:0] ang1, mag1, z_d;
  logic               deg_d, base_d;
  logic        [63:0] az_full;

  e2h_vec #(.STAGES(CORDIC_STAGES)) u_vec_az (
    .clk_i(clk_i), .en_i(en), .x_i(cx_q), .y_i(cy_q), .ang_o(ang1), .mag_o(mag1)
  );

  e2h_dly #(.W(66), .DEPTH(CORDIC_STAGES)) u_dly_az (
    .clk_i(clk_i), .en_i(en), .d_i({cz_q, cdeg_q, cbase_q}), .q_o({z_d, deg_d, base_d})
  );

  assign az_full = deg_d ? '0 : ({base_d, 63'd0} + 64'(ang1));

  // Scale the vertical component by the gain.
  logic signed [63:0] zk, r_e;
  logic        [63:0] az_e;
  logic               deg_e, rz_e, zp_e, zn_e;

  e2h_fmul u_mul_gain (.clk_i(clk_i), .en_i(en), .a_i(z_d), .b_i(GAIN_K), .p_o(zk));

  e2h_dly #(.W(132), .DEPTH(3)) u_dly_gain (
    .clk_i(clk_i), .en_i(en),
    .d_i({mag1, az_full, deg_d, mag1 == '0, !z_d[63] && z_d != '0, z_d[63]}),
    .q_o({r_e, az_e, deg_e, rz_e, zp_e, zn_e})
  );

  // Elevation vectoring.
  logic signed [63:0] ang2;
  logic        [63:0] az_f;
  logic               deg_f, rz_f, zp_f, zn_f;

  e2h_vec #(.STAGES(CORDIC_STAGES)) u_vec_el (
    .clk_i(clk_i), .en_i(en), .x_i(r_e), .y_i(zk), .ang_o(ang2), .mag_o()
  );

  e2h_dly #(.W(68), .DEPTH(CORDIC_STAGES)) u_dly_el (
    .clk_i(clk_i), .en_i(en),
    .d_i({az_e, deg_e, rz_e, zp_e, zn_e}), .q_o({az_f, deg_f, rz_f, zp_f, zn_f})
  );

  // Zero horizontal length, then round both angles to the port width.
  logic [63:0]      el_full, el_rnd, az_rnd;
  logic [RES_W-1:0] res_q;

  always_comb begin
    priority if (!rz_f) begin
      el_full = 64'(ang2);
    end else if (zp_f) begin
      el_full = TURN_QUART;
    end else if (zn_f) begin
      el_full = 64'(-TURN_QUART);
    end else begin
      el_full = '0;
    end
  end

  assign el_rnd = el_full + HALF_LSB;
  assign az_rnd = az_f + HALF_LSB;

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= {el_rnd[63:SHIFT], az_rnd[63:SHIFT], deg_f};
    end
  end

  // Output register with one skid entry.
  logic             xfer;
  logic             out_v_q, out_v_d, skid_v_d;
  logic [RES_W-1:0] out_q, out_d, skid_q, skid_d;

  assign xfer = en && vld_q[LAT-1];

  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (!out_v_q || !out_stall_i) begin
      if (skid_v_q) begin
        out_v_d  = 1'b1;
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end else begin
        out_v_d = xfer;
        out_d   = res_q;
      end
    end else if (xfer) begin
      skid_v_d = 1'b1;
      skid_d   = res_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o  = out_v_q;
  assign elevation_o  = out_q[RES_W-1 -: ANGLE_BITS];
  assign azimuth_o    = out_q[ANGLE_BITS:1];
  assign degenerate_o = out_q[0];

  // The skid entry is only used behind a held result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid entry full without a pending result");

  // The skid entry fills only while the result is held.
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && out_stall_i))
    else $error("skid entry filled while the result register was free");

  // A degenerate direction reports azimuth zero.
  a_degen_az: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && degenerate_o) |-> (azimuth_o == '0))
    else $error("degenerate result with nonzero azimuth");

endmodule

`default_nettype wire
